[rtl/rmsmm_pkg.sv]
// Shared types and constants of the running statistics core.
// Standalone; imported by the top level and the serial arithmetic units.
package rmsmm_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 16;

	// widths of the result fields
	localparam int MEAN_W  = 24;
	localparam int STD_W   = 24;
	localparam int MINMAX_W = 16;
	localparam int COUNT_W = 16;
	localparam int SUM_OUT_W = 32;
	localparam int SQ_OUT_W  = 46;

	// fraction bits of the mean and of the variance
	localparam int MEAN_FRAC = 8;
	localparam int VAR_FRAC  = 16;

	// status of one serial unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_LAUNCH,
		ST_MUL,
		ST_VDIV,
		ST_SQRT,
		ST_FINISH
	} state_t;

endpackage

[rtl/rmsmm_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on rmsmm_pkg for the unit status struct.
module rmsmm_mul #(
	parameter int A_W = 16,
	parameter int B_W = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [A_W-1:0]          a,
	input  logic [B_W-1:0]          b,
	output rmsmm_pkg::unit_stat_t   stat,
	output logic [A_W+B_W-1:0]      product
);
	import rmsmm_pkg::*;

	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic [P_W-1:0]   acc_q;
	logic [A_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// advance one multiplier bit: double and add
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= {acc_q[P_W-2:0], 1'b0} + (b_q[B_W-1] ? P_W'(a_q) : '0);
			b_q   <= {b_q[B_W-2:0], 1'b0};
		end
	end

	assign product = acc_q;
	assign stat    = '{busy: busy_q, done: done_q};

endmodule

[rtl/rmsmm_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on rmsmm_pkg for the unit status struct.
module rmsmm_div #(
	parameter int N_W = 40,
	parameter int D_W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [N_W-1:0]        dividend,
	input  logic [D_W-1:0]        divisor,
	output rmsmm_pkg::unit_stat_t stat,
	output logic [N_W-1:0]        quotient
);
	import rmsmm_pkg::*;

	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             ge;

	assign trial = {rem_q, quo_q[N_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift in one dividend bit, keep the remainder below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], ge};
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign stat     = '{busy: busy_q, done: done_q};

endmodule

[rtl/rmsmm_sqrt.sv]
// Truncating integer square root, two radicand bits per cycle.
// Depends on rmsmm_pkg for the unit status struct.
module rmsmm_sqrt #(
	parameter int V_W = 80
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [V_W-1:0]        radicand,
	output rmsmm_pkg::unit_stat_t stat,
	output logic [V_W/2-1:0]      root
);
	import rmsmm_pkg::*;

	localparam int R_W   = V_W / 2;
	localparam int CNT_W = $clog2(R_W + 1);

	logic [V_W-1:0]   v_q;
	logic [R_W:0]     rem_q;
	logic [R_W-1:0]   root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [R_W+2:0]   t;
	logic [R_W+2:0]   trial;
	logic [R_W+2:0]   diff;
	logic             ge;

	assign t     = {rem_q, v_q[V_W-1:V_W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign diff  = t - trial;
	assign ge    = t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(R_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// take two radicand bits, settle one root bit
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[V_W-3:0], 2'b00};
			rem_q  <= ge ? diff[R_W:0] : t[R_W:0];
			root_q <= {root_q[R_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

[rtl/running_mean_stddev_min_max_core.sv]
// Running statistics core: count, sum, sum of squares, min, max, mean, std dev.
// Depends on rmsmm_pkg, rmsmm_mul, rmsmm_div and rmsmm_sqrt.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   input   | in_valid / in_ready  | sample
//   output  | out_valid / out_ready| mean_q8 std_dev_q8 minimum maximum
//           |                      | sample_count running_sum sum_of_squares
//           |                      | saturated
//
// Each item steps through update, launch, the serial multipliers, the serial
// variance divider (80-bit dividend at the defaults) and the serial square
// root to the finish; the variance divider and square root take longest.
// Reset clears the accumulators to an empty set (min at the most positive,
// max at the most negative sample value). A new item is taken while the
// previous result still waits; a result that is not taken holds the core
// in its final step.
module running_mean_stddev_min_max_core #(
	parameter int SAMPLE_BITS = rmsmm_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = rmsmm_pkg::COUNT_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [SAMPLE_BITS-1:0]          sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [rmsmm_pkg::MEAN_W-1:0]    mean_q8,
	output logic [rmsmm_pkg::STD_W-1:0]            std_dev_q8,
	output logic signed [rmsmm_pkg::MINMAX_W-1:0]  minimum,
	output logic signed [rmsmm_pkg::MINMAX_W-1:0]  maximum,
	output logic [rmsmm_pkg::COUNT_W-1:0]          sample_count,
	output logic signed [rmsmm_pkg::SUM_OUT_W-1:0] running_sum,
	output logic [rmsmm_pkg::SQ_OUT_W-1:0]         sum_of_squares,
	output logic                                   saturated
);
	import rmsmm_pkg::*;

	localparam int SW     = SAMPLE_BITS;
	localparam int CW     = COUNT_BITS;
	localparam int SUM_W  = SW + CW;
	localparam int MAG_W  = SUM_W;
	localparam int SQ_W   = 2 * SW + CW - 1;
	localparam int CS_W   = SQ_W + CW;
	localparam int SS_W   = 2 * MAG_W;
	localparam int NUM_W  = (CS_W > SS_W) ? CS_W : SS_W;
	localparam int VAR_W  = NUM_W + VAR_FRAC + (NUM_W % 2);
	localparam int RT_W   = VAR_W / 2;
	localparam int D_W    = 2 * CW;
	localparam int MQ_W   = MAG_W + MEAN_FRAC;

	// accumulators
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sq_q;
	logic [CW-1:0]           cnt_q;
	logic signed [SW-1:0]    min_q;
	logic signed [SW-1:0]    max_q;

	// the item at work
	logic signed [SW-1:0]    sample_q;
	logic                    sat_q;
	logic [D_W-1:0]          den_q;

	state_t state_q;
	state_t state_d;

	logic in_acc;
	logic upd_en;
	logic launch;
	logic start_v;
	logic start_r;
	logic load_out;

	unit_stat_t cs_stat;
	unit_stat_t ss_stat;
	unit_stat_t md_stat;
	unit_stat_t vd_stat;
	unit_stat_t rt_stat;

	logic [MAG_W-1:0]        mag;
	logic                    sum_neg;
	logic signed [2*SW-1:0]  sq_prod;
	logic [CS_W-1:0]         cs_p;
	logic [SS_W-1:0]         ss_p;
	logic [NUM_W-1:0]        cs_x;
	logic [NUM_W-1:0]        ss_x;
	logic [NUM_W-1:0]        num_v;
	logic [VAR_W-1:0]        var_dvd;
	logic [MQ_W-1:0]         mean_quo;
	logic [VAR_W-1:0]        var_quo;
	logic [RT_W-1:0]         root;
	logic signed [MQ_W:0]    mean_s;

	// output registers
	logic                    out_valid_q;
	logic signed [MEAN_W-1:0]    mean_q;
	logic [STD_W-1:0]            std_q;
	logic signed [MINMAX_W-1:0]  min_out_q;
	logic signed [MINMAX_W-1:0]  max_out_q;
	logic [COUNT_W-1:0]          cnt_out_q;
	logic signed [SUM_OUT_W-1:0] sum_out_q;
	logic [SQ_OUT_W-1:0]         sq_out_q;
	logic                        sat_out_q;

	assign in_acc  = in_valid && in_ready;
	assign sum_neg = sum_q[SUM_W-1];
	assign mag     = sum_neg ? MAG_W'(-sum_q) : MAG_W'(sum_q);
	assign sq_prod = sample_q * sample_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = ST_LAUNCH;
			ST_LAUNCH: state_d = ST_MUL;
			ST_MUL: begin
				if (!cs_stat.busy && !ss_stat.busy)
					state_d = ST_VDIV;
			end
			ST_VDIV: begin
				if (!vd_stat.busy)
					state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (!rt_stat.busy)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if ((!out_valid_q || out_ready) && !md_stat.busy)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		upd_en   = 1'b0;
		launch   = 1'b0;
		start_v  = 1'b0;
		start_r  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_UPDATE: upd_en = 1'b1;
			ST_LAUNCH: launch = 1'b1;
			ST_MUL:    start_v = !cs_stat.busy && !ss_stat.busy;
			ST_VDIV:   start_r = !vd_stat.busy;
			ST_FINISH: load_out = (!out_valid_q || out_ready) && !md_stat.busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// accumulators: hold when the count is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q  <= '0;
			cnt_q <= '0;
			min_q <= {1'b0, {(SW-1){1'b1}}};
			max_q <= {1'b1, {(SW-1){1'b0}}};
		end else if (upd_en && !sat_q) begin
			sum_q <= sum_q + SUM_W'(sample_q);
			sq_q  <= sq_q + SQ_W'($unsigned(sq_prod));
			cnt_q <= cnt_q + 1'b1;
			if (sample_q < min_q)
				min_q <= sample_q;
			if (sample_q > max_q)
				max_q <= sample_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample;
			sat_q    <= (cnt_q == {CW{1'b1}});
		end
		if (launch)
			den_q <= D_W'(cnt_q) * D_W'(cnt_q - 1'b1);
	end

	// n * sum of squares and sum squared run side by side
	rmsmm_mul #(.A_W(SQ_W), .B_W(CW)) u_cs_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (launch),
		.a       (sq_q),
		.b       (cnt_q),
		.stat    (cs_stat),
		.product (cs_p)
	);

	rmsmm_mul #(.A_W(MAG_W), .B_W(MAG_W)) u_ss_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (launch),
		.a       (mag),
		.b       (mag),
		.stat    (ss_stat),
		.product (ss_p)
	);

	// mean magnitude: |sum| * 2^8 / n, in the background of the variance path
	rmsmm_div #(.N_W(MQ_W), .D_W(CW)) u_mean_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (launch),
		.dividend ({mag, {MEAN_FRAC{1'b0}}}),
		.divisor  (cnt_q),
		.stat     (md_stat),
		.quotient (mean_quo)
	);

	// clamp the variance numerator at zero, scale to Q.16
	assign cs_x    = NUM_W'(cs_p);
	assign ss_x    = NUM_W'(ss_p);
	assign num_v   = (cs_x > ss_x) ? (cs_x - ss_x) : '0;
	assign var_dvd = VAR_W'({num_v, {VAR_FRAC{1'b0}}});

	rmsmm_div #(.N_W(VAR_W), .D_W(D_W)) u_var_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_v),
		.dividend (var_dvd),
		.divisor  (den_q),
		.stat     (vd_stat),
		.quotient (var_quo)
	);

	rmsmm_sqrt #(.V_W(VAR_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_r),
		.radicand (var_quo),
		.stat     (rt_stat),
		.root     (root)
	);

	// restore the sign of the mean, truncating toward zero
	assign mean_s = sum_neg ? -$signed({1'b0, mean_quo}) : $signed({1'b0, mean_quo});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mean_q    <= (cnt_q == '0) ? '0 : MEAN_W'(mean_s);
			std_q     <= (cnt_q <= CW'(1)) ? '0 : STD_W'(root);
			min_out_q <= MINMAX_W'(min_q);
			max_out_q <= MINMAX_W'(max_q);
			cnt_out_q <= COUNT_W'(cnt_q);
			sum_out_q <= SUM_OUT_W'(sum_q);
			sq_out_q  <= SQ_OUT_W'(sq_q);
			sat_out_q <= sat_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign mean_q8        = mean_q;
	assign std_dev_q8     = std_q;
	assign minimum        = min_out_q;
	assign maximum        = max_out_q;
	assign sample_count   = cnt_out_q;
	assign running_sum    = sum_out_q;
	assign sum_of_squares = sq_out_q;
	assign saturated      = sat_out_q;

`ifndef SYNTHESIS
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !(cs_stat.busy || ss_stat.busy || md_stat.busy ||
			vd_stat.busy || rt_stat.busy))
		else $error("item accepted while a serial unit is busy");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_UPDATE |=> $stable(cnt_q))
		else $error("count moved outside the update step");

	a_single_std: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && cnt_q <= CW'(1) |=> std_dev_q8 == '0)
		else $error("nonzero deviation for a single sample");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> min_q <= max_q)
		else $error("minimum above maximum");
`endif

endmodule

[sim/running_mean_stddev_min_max_core_tb.sv]
// Self-checking testbench for running_mean_stddev_min_max_core.
// Needs rmsmm_pkg and the core; a built-in predictor checks every result item.
module running_mean_stddev_min_max_core_tb;
	import rmsmm_pkg::*;

	// One result item, field by field, at the port widths.
	typedef struct packed {
		logic signed [MEAN_W-1:0]    mean;
		logic [STD_W-1:0]            sdev;
		logic signed [MINMAX_W-1:0]  mn;
		logic signed [MINMAX_W-1:0]  mx;
		logic [COUNT_W-1:0]          cnt;
		logic signed [SUM_OUT_W-1:0] sum;
		logic [SQ_OUT_W-1:0]         sumsq;
		logic                        sat;
	} stats_t;

	// Directed row: a sample and, where obvious, the result typed in.
	typedef struct {
		logic signed [15:0] smp;
		bit                 typed;
		stats_t             want;
	} row_t;

	localparam int N_DIR    = 14;
	localparam int N_RAND   = 1230;
	localparam int CNT_FULL = 65535;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [MEAN_W-1:0] mean_q8;
	logic [STD_W-1:0] std_dev_q8;
	logic signed [MINMAX_W-1:0] minimum;
	logic signed [MINMAX_W-1:0] maximum;
	logic [COUNT_W-1:0] sample_count;
	logic signed [SUM_OUT_W-1:0] running_sum;
	logic [SQ_OUT_W-1:0] sum_of_squares;
	logic saturated;

	// Predictor state: running accumulators of all accepted samples.
	longint acc_total;
	logic [63:0] acc_sq;
	int acc_n;
	int acc_lo;
	int acc_hi;

	stats_t stats_q[$];
	int mismatches = 0;
	bit idle_on = 1'b1;
	bit cur_typed = 1'b0;
	stats_t cur_want;
	row_t dir_tab[N_DIR];

	always #6 clk = ~clk;

	running_mean_stddev_min_max_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.mean_q8(mean_q8), .std_dev_q8(std_dev_q8),
		.minimum(minimum), .maximum(maximum),
		.sample_count(sample_count), .running_sum(running_sum),
		.sum_of_squares(sum_of_squares), .saturated(saturated)
	);

	// Truncating integer square root, two radicand bits per pass.
	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bit_w;
		root = '0;
		bit_w = 64'd1 << 62;
		while (bit_w > v)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= root + bit_w) begin
				v = v - (root + bit_w);
				root = (root >> 1) + bit_w;
			end else begin
				root = root >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return root;
	endfunction

	// Sample standard deviation in Q.8 from the current accumulators.
	function automatic logic [63:0] stddev_q8();
		logic [63:0] n, mag, cs, ss, num, d, q, r, var_q16;
		if (acc_n <= 1)
			return 64'd0;
		n = 64'(acc_n);
		mag = (acc_total < 0) ? -acc_total : acc_total;
		cs = n * acc_sq;
		ss = mag * mag;
		num = (cs > ss) ? cs - ss : 64'd0;
		d = n * (n - 64'd1);
		q = num / d;
		r = num % d;
		var_q16 = (q << 16) + (r << 16) / d;
		return int_sqrt(var_q16);
	endfunction

	// Fold one sample into the accumulators and return the stats it yields.
	function automatic stats_t accumulate(logic signed [15:0] s);
		stats_t res;
		longint sv;
		longint mean_full;
		bit full;
		sv = s;
		full = (acc_n >= CNT_FULL);
		if (!full) begin
			acc_total += sv;
			acc_sq += 64'(sv * sv);
			acc_n++;
			if (sv < acc_lo)
				acc_lo = sv;
			if (sv > acc_hi)
				acc_hi = sv;
		end
		mean_full = (acc_n != 0) ? (acc_total * 256) / longint'(acc_n) : 0;
		res.mean  = mean_full[MEAN_W-1:0];
		res.sdev  = STD_W'(stddev_q8());
		res.mn    = acc_lo[15:0];
		res.mx    = acc_hi[15:0];
		res.cnt   = acc_n[15:0];
		res.sum   = acc_total[31:0];
		res.sumsq = acc_sq[SQ_OUT_W-1:0];
		res.sat   = full;
		return res;
	endfunction

	function automatic void check_fields(stats_t w, stats_t g);
		if (g.mean !== w.mean) begin
			$error("mean_q8: expected %0d, got %0d", w.mean, g.mean);
			mismatches++;
		end
		if (g.sdev !== w.sdev) begin
			$error("std_dev_q8: expected %0d, got %0d", w.sdev, g.sdev);
			mismatches++;
		end
		if (g.mn !== w.mn) begin
			$error("minimum: expected %0d, got %0d", w.mn, g.mn);
			mismatches++;
		end
		if (g.mx !== w.mx) begin
			$error("maximum: expected %0d, got %0d", w.mx, g.mx);
			mismatches++;
		end
		if (g.cnt !== w.cnt) begin
			$error("sample_count: expected %0d, got %0d", w.cnt, g.cnt);
			mismatches++;
		end
		if (g.sum !== w.sum) begin
			$error("running_sum: expected %0d, got %0d", w.sum, g.sum);
			mismatches++;
		end
		if (g.sumsq !== w.sumsq) begin
			$error("sum_of_squares: expected %0d, got %0d", w.sumsq, g.sumsq);
			mismatches++;
		end
		if (g.sat !== w.sat) begin
			$error("saturated: expected %0d, got %0d", w.sat, g.sat);
			mismatches++;
		end
	endfunction

	// Watch both channels at the rising edge: predict on input items, check
	// output items against the oldest expectation.
	always @(posedge clk) begin
		stats_t pred;
		stats_t got;
		if (arst_n && in_valid && in_ready) begin
			pred = accumulate(sample);
			stats_q.push_back(cur_typed ? cur_want : pred);
		end
		if (arst_n && out_valid && out_ready) begin
			got = '{mean_q8, std_dev_q8, minimum, maximum, sample_count,
				running_sum, sum_of_squares, saturated};
			if (stats_q.size() == 0) begin
				$error("unexpected result item: sample_count %0d", sample_count);
				mismatches++;
			end else begin
				check_fields(stats_q.pop_front(), got);
			end
		end
	end

	// Result side: while idling is on, stall a random number of cycles before each item.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = idle_on ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				@(negedge clk);
				out_ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Present one item, after a random gap while idling is on; hold it until taken.
	task automatic send_item(logic signed [15:0] s, bit typed, stats_t want);
		int gap;
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		sample = s;
		cur_typed = typed;
		cur_want = want;
		do @(posedge clk); while (!in_ready);
	endtask

	// Mostly full-range values, with extremes and small values mixed in.
	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2, 3: return 16'($signed($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		dir_tab[0]  = '{16'sd5, 1'b1, '{24'sd1280, 24'd0, 16'sd5, 16'sd5, 16'd1,
			32'sd5, 46'd25, 1'b0}};
		dir_tab[1]  = '{-16'sd32768, 1'b0, '0};
		dir_tab[2]  = '{16'sd32767, 1'b0, '0};
		dir_tab[3]  = '{16'sd0, 1'b0, '0};
		dir_tab[4]  = '{-16'sd1, 1'b0, '0};
		dir_tab[5]  = '{16'sd1, 1'b0, '0};
		dir_tab[6]  = '{16'sh5555, 1'b0, '0};
		dir_tab[7]  = '{16'shaaaa, 1'b0, '0};
		dir_tab[8]  = '{16'sd32767, 1'b0, '0};
		dir_tab[9]  = '{16'sd32767, 1'b0, '0};
		dir_tab[10] = '{-16'sd32768, 1'b0, '0};
		dir_tab[11] = '{-16'sd32768, 1'b0, '0};
		dir_tab[12] = '{16'sd255, 1'b0, '0};
		dir_tab[13] = '{-16'sd256, 1'b0, '0};

		acc_total = 0;
		acc_sq = '0;
		acc_n = 0;
		acc_lo = 32767;
		acc_hi = -32768;

		// Hold reset, then release it away from the rising edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: the row after reset carries its result typed in.
		foreach (dir_tab[i])
			send_item(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].want);

		// Random part, in blocks with and without idling.
		for (int i = 0; i < N_RAND; i++) begin
			if (i % 100 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (i == N_RAND / 2) begin
				// Drain fully before the next item.
				@(negedge clk);
				in_valid = 1'b0;
				wait (stats_q.size() == 0);
			end
			send_item(pick_sample(), 1'b0, '0);
		end

		// Close with a few more items under idling.
		idle_on = 1'b1;
		repeat (12)
			send_item(pick_sample(), 1'b0, '0);

		@(negedge clk);
		in_valid = 1'b0;
		wait (stats_q.size() == 0);
		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// A full run takes roughly 3M time units; allow several times that.
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
rtl/rmsmm_pkg.sv
rtl/rmsmm_mul.sv
rtl/rmsmm_div.sv
rtl/rmsmm_sqrt.sv
rtl/running_mean_stddev_min_max_core.sv
sim/running_mean_stddev_min_max_core_tb.sv
